/* design/next_fit_free_list_allocator_macros.svh */
// Assertion macros for the next-fit allocator checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFFLA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nffla assertion failed");

// next-cycle implication
`define NFFLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nffla assertion failed");

`endif

/* design/nffla_pkg.sv */
// Shared types and constants for the next-fit free-list allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package nffla_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int IDX_W      = $clog2(HEAP_UNITS);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int CFG_ADDR_W = 3;

    localparam logic [SIZE_W-1:0] HEAP_UNITS_S   = SIZE_W'(HEAP_UNITS);
    localparam logic [15:0]       HEAP_BYTES_RST = 16'd65520;
    localparam logic              REG_HEAP_BYTES = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]  next;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ZERO   = 2'd1,
        ST_NOFIT  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_FIRST,
        S_A_CHK,
        S_A_TAIL,
        S_R_HDR,
        S_R_WALK,
        S_R_CHK,
        S_R_MNX,
        S_R_WFB,
        S_R_PREV,
        S_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_A_FIRST,
        OP_A_STEP,
        OP_A_UNLINK,
        OP_A_CUT,
        OP_A_TAIL,
        OP_R_SOLO,
        OP_R_START,
        OP_R_STEP,
        OP_R_FOUND,
        OP_R_COMMIT,
        OP_R_MSOLO,
        OP_R_MNX,
        OP_R_WFB,
        OP_R_LINK
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    res_set;
        status_t res_code;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic zero_req;
        logic list_empty;
        logic addr_bad;
        logic hdr_bad;
        logic fits;
        logic exact;
        logic at_start;
        logic walk_limit;
        logic found_in;
        logic hit;
        logic found_wrap;
        logic overlap;
        logic merge_next;
        logic single;
    } stat_t;

endpackage

`default_nettype wire

/* design/next_fit_free_list_allocator.sv */
// Top level of the next-fit free-list allocator: APB register decode and the two units.
// Depends on nffla_pkg, nffla_ctrl and nffla_dpath.
//
// Usage:
//   Request channel (req_valid/req_stall) carries kind, request_bytes and
//   release_address; a transaction is taken when req_valid is high and
//   req_stall low. Each request yields exactly one response transaction on
//   rsp_valid/rsp_stall with status, payload_address and free_units.
//   One request is processed at a time, one header read per cycle from the
//   single read port of the header memory. A zero-size request, an empty
//   list or a bad address goes straight to the response; a bad header or
//   a release into an empty list ends once its header is read; an allocate
//   reads free blocks until one fits or the walk ends (a cut block gets a
//   tail header), and a release walks headers, then checks and links it.
//   After the response is loaded, the next request is taken in idle.
//   A finished response sits in an output register; while a stalled
//   response holds there, the next finished one waits and req_stall stays high.
//   Reset rebuilds the heap as one free block in state S_INIT, with
//   req_stall high; a write of heap_bytes does the same after in-flight
//   work ends and holds req_stall high after the write until the rebuild.
`default_nettype none

module next_fit_free_list_allocator
    import nffla_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic                  kind,
    input  wire logic [15:0]           request_bytes,
    input  wire logic [15:0]           release_address,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [1:0]                 status,
    output logic [15:0]                payload_address,
    output logic [12:0]                free_units,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    cmd_t        cmd;
    stat_t       stat;
    logic        cfg_we;
    logic [15:0] heap_bytes;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_HEAP_BYTES);
    assign prdata = (paddr[2] == REG_HEAP_BYTES) ? {16'd0, heap_bytes} : 32'd0;

    nffla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_we    (cfg_we),
        .stat      (stat),
        .cmd       (cmd)
    );

    nffla_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_wdata       (pwdata[15:0]),
        .kind            (kind),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .stat            (stat),
        .heap_bytes      (heap_bytes),
        .status          (status),
        .payload_address (payload_address),
        .free_units      (free_units)
    );

endmodule

`default_nettype wire

/* design/nffla_dpath.sv */
// Datapath: header memory, rover, free count, walk registers and result registers.
// Depends on nffla_pkg; driven by commands from nffla_ctrl.
`default_nettype none

module nffla_dpath
    import nffla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        kind,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] release_address,
    output stat_t            stat,
    output logic [15:0]      heap_bytes,
    output logic [1:0]       status,
    output logic [15:0]      payload_address,
    output logic [12:0]      free_units
);

    hdr_t mem [HEAP_UNITS];
    hdr_t rd_q;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    hdr_t              wr_data;

    logic [15:0]       heap_bytes_reg;
    logic [IDX_W-1:0]  rover_reg;
    logic [SIZE_W-1:0] free_reg;

    logic [SIZE_W-1:0] need_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [IDX_W-1:0]  prev_reg;
    logic [SIZE_W-1:0] prev_size_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [SIZE_W-1:0] cur_size_reg;
    logic [IDX_W-1:0]  nx_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [SIZE_W-1:0] n_reg;
    logic [IDX_W-1:0]  fb_reg;
    logic [SIZE_W-1:0] fs_reg;
    logic              wrap_reg;
    logic [IDX_W-1:0]  fb_next_reg;
    logic [SIZE_W-1:0] fb_size_reg;
    status_t           res_status_reg;
    logic [15:0]       res_payload_reg;
    status_t           status_reg;
    logic [15:0]       payload_reg;
    logic [12:0]       free_out_reg;

    logic [16:0]       hb_units;
    logic [SIZE_W-1:0] heap_units;
    logic [16:0]       req_units;
    logic [SIZE_W-1:0] need_in;
    logic [IDX_W-1:0]  fb_in;
    logic [SIZE_W-1:0] rem_size;
    logic [SIZE_W-1:0] free_after_alloc;
    logic [SIZE_W:0]   cur_end;
    logic [SIZE_W:0]   fb_end;
    logic              merge_prev;

    function automatic logic [15:0] pay_of(input logic [IDX_W-1:0] u);
        logic [IDX_W:0] u1;
        u1 = {1'b0, u} + 1'b1;
        return 16'({u1, {UNIT_SHIFT{1'b0}}});
    endfunction

    // heap size in units, header unit included, capped at the memory depth
    assign hb_units   = ((17'(heap_bytes_reg) + 17'(UNIT_BYTES - 1)) >> UNIT_SHIFT) + 17'd1;
    assign heap_units = (hb_units > 17'(HEAP_UNITS)) ? HEAP_UNITS_S : SIZE_W'(hb_units);
    assign req_units  = ((17'(request_bytes) + 17'(UNIT_BYTES - 1)) >> UNIT_SHIFT) + 17'd1;
    assign need_in    = SIZE_W'(req_units);
    assign fb_in      = IDX_W'(release_address[15:UNIT_SHIFT]) - 1'b1;

    assign rem_size         = rd_q.size - need_reg;
    assign free_after_alloc = (free_reg >= need_reg) ? (free_reg - need_reg) : '0;
    assign cur_end          = (SIZE_W+1)'(cur_reg) + (SIZE_W+1)'(cur_size_reg);
    assign fb_end           = (SIZE_W+1)'(fb_reg) + (SIZE_W+1)'(fs_reg);
    assign merge_prev       = (cur_end == (SIZE_W+1)'(fb_reg));

    always_comb
    begin
        stat.zero_req   = (request_bytes == 16'd0);
        stat.list_empty = (free_reg == '0);
        stat.addr_bad   = (release_address == 16'd0)
                       || (release_address[UNIT_SHIFT-1:0] != '0)
                       || ({1'b0, fb_in} >= heap_units);
        stat.hdr_bad    = (rd_q.size == '0)
                       || (((SIZE_W+1)'(fb_reg) + (SIZE_W+1)'(rd_q.size))
                           > (SIZE_W+1)'(heap_units));
        stat.fits       = (rd_q.size >= need_reg);
        stat.exact      = (rd_q.size == need_reg);
        stat.at_start   = (cur_reg == start_reg);
        stat.walk_limit = (n_reg == HEAP_UNITS_S);
        stat.found_in   = (fb_reg > cur_reg) && (fb_reg < rd_q.next);
        stat.hit        = (cur_reg == fb_reg) || (rd_q.next == fb_reg);
        stat.found_wrap = (cur_reg >= rd_q.next) && ((fb_reg > cur_reg) || (fb_reg < rd_q.next));
        if (wrap_reg)
        begin
            stat.overlap = ((fb_reg > cur_reg) && (cur_end > (SIZE_W+1)'(fb_reg)))
                        || ((fb_reg < nx_reg) && (fb_end > (SIZE_W+1)'(nx_reg)));
        end
        else
        begin
            stat.overlap = (cur_end > (SIZE_W+1)'(fb_reg)) || (fb_end > (SIZE_W+1)'(nx_reg));
        end
        stat.merge_next = (fb_end == (SIZE_W+1)'(nx_reg));
        stat.single     = (nx_reg == cur_reg);
    end

    always_comb
    begin
        case (cmd.op)
            OP_ACCEPT:  rd_addr = kind ? fb_in : rover_reg;
            OP_A_FIRST: rd_addr = rd_q.next;
            OP_A_STEP:  rd_addr = rd_q.next;
            OP_R_START: rd_addr = rover_reg;
            OP_R_STEP:  rd_addr = rd_q.next;
            OP_R_COMMIT: rd_addr = nx_reg;
            default:    rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cur_reg;
        wr_data = '{next: cur_reg, size: cur_size_reg};
        case (cmd.op)
            OP_INIT:
            begin
                wr_addr = '0;
                wr_data = '{next: '0, size: heap_units};
            end
            OP_A_UNLINK:
            begin
                wr_addr = prev_reg;
                wr_data = '{next: rd_q.next, size: prev_size_reg};
            end
            OP_A_CUT:
            begin
                wr_addr = cur_reg;
                wr_data = '{next: rd_q.next, size: rem_size};
            end
            OP_A_TAIL:
            begin
                wr_addr = tail_reg;
                wr_data = '{next: '0, size: need_reg};
            end
            OP_R_SOLO:
            begin
                wr_addr = fb_reg;
                wr_data = '{next: fb_reg, size: rd_q.size};
            end
            OP_R_MSOLO:
            begin
                wr_addr = fb_reg;
                wr_data = '{next: fb_reg, size: fs_reg + rd_q.size};
            end
            OP_R_WFB:
            begin
                wr_addr = fb_reg;
                wr_data = '{next: fb_next_reg, size: fb_size_reg};
            end
            OP_R_LINK:
            begin
                wr_addr = cur_reg;
                if (merge_prev)
                begin
                    wr_data = '{next: fb_next_reg, size: cur_size_reg + fb_size_reg};
                end
                else
                begin
                    wr_data = '{next: fb_reg, size: cur_size_reg};
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_bytes_reg <= HEAP_BYTES_RST;
            rover_reg      <= '0;
            free_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_bytes_reg <= cfg_wdata;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    rover_reg <= '0;
                    free_reg  <= heap_units;
                end
                OP_A_UNLINK, OP_A_CUT:
                begin
                    rover_reg <= prev_reg;
                    free_reg  <= free_after_alloc;
                end
                OP_R_SOLO:
                begin
                    rover_reg <= fb_reg;
                    free_reg  <= rd_q.size;
                end
                OP_R_COMMIT:
                begin
                    free_reg <= free_reg + fs_reg;
                end
                OP_R_MSOLO:
                begin
                    rover_reg <= fb_reg;
                end
                OP_R_LINK:
                begin
                    rover_reg <= cur_reg;
                end
                default:
                begin
                    rover_reg <= rover_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                need_reg        <= need_in;
                start_reg       <= rover_reg;
                prev_reg        <= rover_reg;
                fb_reg          <= fb_in;
                n_reg           <= '0;
                res_payload_reg <= 16'd0;
            end
            OP_A_FIRST:
            begin
                prev_size_reg <= rd_q.size;
                cur_reg       <= rd_q.next;
            end
            OP_A_STEP:
            begin
                prev_reg      <= cur_reg;
                prev_size_reg <= rd_q.size;
                cur_reg       <= rd_q.next;
                n_reg         <= n_reg + 1'b1;
            end
            OP_A_UNLINK:
            begin
                res_payload_reg <= pay_of(cur_reg);
            end
            OP_A_CUT:
            begin
                // the granted block is the tail of the one found
                tail_reg <= cur_reg + rem_size[IDX_W-1:0];
            end
            OP_A_TAIL:
            begin
                res_payload_reg <= pay_of(tail_reg);
            end
            OP_R_START:
            begin
                fs_reg  <= rd_q.size;
                cur_reg <= rover_reg;
                n_reg   <= '0;
            end
            OP_R_STEP:
            begin
                cur_reg <= rd_q.next;
                n_reg   <= n_reg + 1'b1;
            end
            OP_R_FOUND:
            begin
                wrap_reg     <= !stat.found_in;
                nx_reg       <= rd_q.next;
                cur_size_reg <= rd_q.size;
            end
            OP_R_COMMIT:
            begin
                fb_size_reg <= fs_reg;
                fb_next_reg <= nx_reg;
            end
            OP_R_MNX:
            begin
                fb_size_reg <= fs_reg + rd_q.size;
                fb_next_reg <= rd_q.next;
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase

        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
        end
        if (cmd.load_out)
        begin
            status_reg   <= res_status_reg;
            payload_reg  <= res_payload_reg;
            free_out_reg <= free_reg;
        end
    end

    assign heap_bytes      = heap_bytes_reg;
    assign status          = status_reg;
    assign payload_address = payload_reg;
    assign free_units      = free_out_reg;

endmodule

`default_nettype wire

/* design/nffla_ctrl.sv */
// Controller state machine: sequences allocate and release walks over the header memory.
// Depends on nffla_pkg; issues commands to nffla_dpath and reads its status flags.
`default_nettype none

module nffla_ctrl
    import nffla_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire logic  kind,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    input  wire logic  cfg_we,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   restart_reg, restart_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE) || restart_reg;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:    state_next = S_IDLE;
            S_IDLE:
            begin
                if (restart_reg)
                begin
                    state_next = S_INIT;
                end
                else if (accept)
                begin
                    if (!kind)
                    begin
                        state_next = (stat.zero_req || stat.list_empty) ? S_FIN : S_A_FIRST;
                    end
                    else
                    begin
                        state_next = stat.addr_bad ? S_FIN : S_R_HDR;
                    end
                end
            end
            S_A_FIRST: state_next = S_A_CHK;
            S_A_CHK:
            begin
                if (stat.fits)
                begin
                    state_next = stat.exact ? S_FIN : S_A_TAIL;
                end
                else if (stat.at_start || stat.walk_limit)
                begin
                    state_next = S_FIN;
                end
            end
            S_A_TAIL:  state_next = S_FIN;
            S_R_HDR:
            begin
                if (stat.hdr_bad || stat.list_empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_R_WALK;
                end
            end
            S_R_WALK:
            begin
                if (stat.found_in)
                begin
                    state_next = S_R_CHK;
                end
                else if (stat.hit)
                begin
                    state_next = S_FIN;
                end
                else if (stat.found_wrap)
                begin
                    state_next = S_R_CHK;
                end
                else if (stat.walk_limit)
                begin
                    state_next = S_FIN;
                end
            end
            S_R_CHK:
            begin
                if (stat.overlap)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = stat.merge_next ? S_R_MNX : S_R_WFB;
                end
            end
            S_R_MNX:   state_next = stat.single ? S_FIN : S_R_WFB;
            S_R_WFB:   state_next = S_R_PREV;
            S_R_PREV:  state_next = S_FIN;
            S_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        cmd          = '{op: OP_NONE, res_set: 1'b0, res_code: ST_DONE, load_out: 1'b0};
        restart_next = restart_reg;
        if (cfg_we)
        begin
            restart_next = 1'b1;
        end
        case (state_reg)
            S_INIT:
            begin
                cmd.op       = OP_INIT;
                restart_next = cfg_we;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = OP_ACCEPT;
                    if (!kind)
                    begin
                        if (stat.zero_req)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = ST_ZERO;
                        end
                        else if (stat.list_empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = ST_NOFIT;
                        end
                    end
                    else if (stat.addr_bad)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ST_REJECT;
                    end
                end
            end
            S_A_FIRST:
            begin
                cmd.op = OP_A_FIRST;
            end
            S_A_CHK:
            begin
                if (stat.fits)
                begin
                    cmd.op = stat.exact ? OP_A_UNLINK : OP_A_CUT;
                    cmd.res_set  = stat.exact;
                    cmd.res_code = ST_DONE;
                end
                else if (stat.at_start || stat.walk_limit)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOFIT;
                end
                else
                begin
                    cmd.op = OP_A_STEP;
                end
            end
            S_A_TAIL:
            begin
                cmd.op       = OP_A_TAIL;
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_DONE;
            end
            S_R_HDR:
            begin
                if (stat.hdr_bad)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_REJECT;
                end
                else if (stat.list_empty)
                begin
                    cmd.op       = OP_R_SOLO;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_DONE;
                end
                else
                begin
                    cmd.op = OP_R_START;
                end
            end
            S_R_WALK:
            begin
                if (stat.found_in)
                begin
                    cmd.op = OP_R_FOUND;
                end
                else if (stat.hit)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_REJECT;
                end
                else if (stat.found_wrap)
                begin
                    cmd.op = OP_R_FOUND;
                end
                else if (stat.walk_limit)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_REJECT;
                end
                else
                begin
                    cmd.op = OP_R_STEP;
                end
            end
            S_R_CHK:
            begin
                if (stat.overlap)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_REJECT;
                end
                else
                begin
                    cmd.op = OP_R_COMMIT;
                end
            end
            S_R_MNX:
            begin
                if (stat.single)
                begin
                    cmd.op       = OP_R_MSOLO;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_DONE;
                end
                else
                begin
                    cmd.op = OP_R_MNX;
                end
            end
            S_R_WFB:
            begin
                cmd.op = OP_R_WFB;
            end
            S_R_PREV:
            begin
                cmd.op       = OP_R_LINK;
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_DONE;
            end
            S_FIN:
            begin
                cmd.load_out = !out_valid_reg || !rsp_stall;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp_valid && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/nffla_checker.sv */
// Port-level checker for the next-fit free-list allocator, bound to the top level.
// Depends on nffla_pkg and next_fit_free_list_allocator_macros.svh.
`default_nettype none
`include "next_fit_free_list_allocator_macros.svh"

module nffla_checker
    import nffla_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [1:0]  status,
    input wire logic [15:0] payload_address,
    input wire logic [12:0] free_units
);

    // hold a stalled response
    `NFFLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    // one request at a time: stall right after a transaction is taken
    `NFFLA_ASSERT_NEXT(a_one_busy, req_valid && !req_stall, req_stall)
    // only a successful allocate carries an address
    `NFFLA_ASSERT_IMPL(a_addr_zero, rsp_valid && (status != ST_DONE), payload_address == 16'd0)
    // free count never exceeds the heap
    `NFFLA_ASSERT_IMPL(a_free_max, rsp_valid, free_units <= 13'(HEAP_UNITS))

endmodule

bind next_fit_free_list_allocator nffla_checker u_nffla_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .payload_address (payload_address),
    .free_units      (free_units)
);

`default_nettype wire
